@@ rtl/wconv_pkg.sv @@
// Shared types, widths and codes for the 2-D sliding-window convolution core.
`timescale 1ns / 1ps
`default_nettype none

package wconv_pkg;

  // Parameter defaults
  localparam int unsigned KERNEL_SIZE_DEF = 3;
  localparam int unsigned MAX_WIDTH_DEF   = 1024;

  // Field widths
  localparam int unsigned PIXEL_W    = 8;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned COEF_IDX_W = 4;
  localparam int unsigned RESULT_W   = 29;
  localparam int unsigned PWIDTH_W   = 11;
  localparam int unsigned PHEIGHT_W  = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  // One product of an unsigned pixel and a signed coefficient.
  localparam int unsigned PROD_W = PIXEL_W + 1 + COEF_W;

  // Register reset values
  localparam logic [PWIDTH_W-1:0]  PWIDTH_RST  = 11'd1024;
  localparam logic [PHEIGHT_W-1:0] PHEIGHT_RST = 16'd1024;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PADDED_WIDTH  = 1'b0,
    CFG_PADDED_HEIGHT = 1'b1
  } cfg_reg_e;

  // Input item commands
  typedef enum logic {
    CMD_COEF  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                      command;
    logic [COEF_IDX_W-1:0]     coef_index;
    logic signed [COEF_W-1:0]  coef_value;
    logic [PIXEL_W-1:0]        pixel;
  } wconv_in_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] filtered_value;
    logic                       last_of_image;
  } wconv_out_t;

  // Control that travels with a window into the sum pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } wconv_tag_t;

endpackage

`default_nettype wire

@@ rtl/wconv_line_buf.sv @@
// Line buffer memory: one word per column holding the previous image rows.
`timescale 1ns / 1ps
`default_nettype none

module wconv_line_buf #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned DATA_W = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; a same-cycle write is not seen.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/wconv_sum.sv @@
// Multiply and adder-tree pipeline that turns a window into one filtered value.
`timescale 1ns / 1ps
`default_nettype none

module wconv_sum #(
  parameter int unsigned KERNEL_SIZE = wconv_pkg::KERNEL_SIZE_DEF
) (
  input  logic                                                      clk_i,
  input  logic                                                      rst_ni,
  input  wconv_pkg::wconv_tag_t                                     tag_i,
  output logic                                                      ready_o,
  input  logic [KERNEL_SIZE*KERNEL_SIZE-1:0][wconv_pkg::PIXEL_W-1:0] window_i,
  input  logic [KERNEL_SIZE*KERNEL_SIZE-1:0][wconv_pkg::COEF_W-1:0]  kernel_i,
  output logic                                                      out_valid_o,
  input  logic                                                      out_stall_i,
  output wconv_pkg::wconv_out_t                                     out_data_o
);

  import wconv_pkg::*;

  localparam int unsigned TAPS  = KERNEL_SIZE * KERNEL_SIZE;
  localparam int unsigned GROW_W = PROD_W + $clog2(TAPS);
  localparam int unsigned SUM_W = (GROW_W > RESULT_W) ? GROW_W : RESULT_W;

  logic signed [PROD_W-1:0] prod_d [TAPS];
  logic signed [PROD_W-1:0] prod_q [TAPS];
  logic signed [SUM_W-1:0]  rsum_d [KERNEL_SIZE];
  logic signed [SUM_W-1:0]  rsum_q [KERNEL_SIZE];
  logic signed [SUM_W-1:0]  total_d;
  logic                     prod_v_q, prod_last_q;
  logic                     rsum_v_q, rsum_last_q;
  logic                     out_v_q;
  wconv_out_t               out_q;
  logic                     out_ready, rsum_ready, prod_ready;

  // Each stage moves when the one after it is empty or moving.
  assign out_ready  = !out_v_q || !out_stall_i;
  assign rsum_ready = !rsum_v_q || out_ready;
  assign prod_ready = !prod_v_q || rsum_ready;
  assign ready_o    = prod_ready;

  // Per-tap products of pixel and signed coefficient.
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      prod_d[i] = $signed({1'b0, window_i[i]}) * $signed(kernel_i[i]);
    end
  end

  // Row sums of the registered products.
  always_comb begin
    for (int y = 0; y < KERNEL_SIZE; y++) begin
      rsum_d[y] = '0;
      for (int x = 0; x < KERNEL_SIZE; x++) begin
        rsum_d[y] = rsum_d[y] + SUM_W'(prod_q[y*KERNEL_SIZE+x]);
      end
    end
  end

  // Final sum over the rows.
  always_comb begin
    total_d = '0;
    for (int y = 0; y < KERNEL_SIZE; y++) begin
      total_d = total_d + rsum_q[y];
    end
  end

  // Stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      rsum_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_v_q <= tag_i.valid;
      end
      if (rsum_ready) begin
        rsum_v_q <= prod_v_q;
      end
      if (out_ready) begin
        out_v_q <= rsum_v_q;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (prod_ready && tag_i.valid) begin
      prod_q      <= prod_d;
      prod_last_q <= tag_i.last;
    end
    if (rsum_ready && prod_v_q) begin
      rsum_q      <= rsum_d;
      rsum_last_q <= prod_last_q;
    end
    if (out_ready && rsum_v_q) begin
      out_q.filtered_value <= total_d[RESULT_W-1:0];
      out_q.last_of_image  <= rsum_last_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/window_convolution_2d_core.sv @@
// Top level of the K by K sliding-window convolution core.
// A pixel's result passes the input, product, row-sum and output registers in turn.
// Throughput: one item per cycle unless a held pixel waits on a full sum pipeline.
// Reset: asynchronous, clears kernel, window, counters, and sets both sizes to 1024.
// The line buffer memory is not cleared; no emitted result reads an unwritten entry.
`timescale 1ns / 1ps
`default_nettype none

module window_convolution_2d_core #(
  parameter int unsigned KERNEL_SIZE = wconv_pkg::KERNEL_SIZE_DEF,
  parameter int unsigned MAX_WIDTH   = wconv_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wconv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wconv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  wconv_pkg::wconv_in_t             in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output wconv_pkg::wconv_out_t            out_data_o
);

  import wconv_pkg::*;

  localparam int unsigned TAPS    = KERNEL_SIZE * KERNEL_SIZE;
  localparam int unsigned CW      = $clog2(MAX_WIDTH);
  localparam int unsigned WEW     = (CW + 1 > PWIDTH_W) ? CW + 1 : PWIDTH_W;
  localparam int unsigned LB_ROWS = (KERNEL_SIZE > 1) ? KERNEL_SIZE - 1 : 1;
  localparam int unsigned LB_W    = LB_ROWS * PIXEL_W;

  // Configuration and position state
  logic [PWIDTH_W-1:0]  width_q;
  logic [PHEIGHT_W-1:0] height_q;
  logic [CW-1:0]        col_q, col_d;
  logic [PHEIGHT_W-1:0] row_q, row_d;
  logic [WEW-1:0]       w_eff, c_inc;
  logic [PHEIGHT_W-1:0] h_eff;
  logic [CW-1:0]        c_eff;
  logic [PHEIGHT_W-1:0] r_eff;
  logic [PHEIGHT_W:0]   r_inc;
  logic                 emit_d, last_d;

  // Input register stage
  logic                 in_xfer;
  logic                 s1_v_q;
  wconv_in_t            s1_data_q;
  logic [CW-1:0]        s1_col_q;
  logic                 s1_emit_q, s1_last_q;
  logic                 s1_is_pix, s1_go;

  // Line buffer and forwarding
  logic [LB_ROWS-1:0][PIXEL_W-1:0] lb_rd, lb_col, lb_wdata, lb_fwd_data_q;
  logic                            lb_fwd_q;

  // Window and kernel
  logic [TAPS-1:0][PIXEL_W-1:0]     window_q, window_d;
  logic [TAPS-1:0][COEF_W-1:0]      kernel_q, kernel_d;
  logic [KERNEL_SIZE-1:0][PIXEL_W-1:0] col_pix;

  wconv_tag_t sum_tag;
  logic       sum_ready;

  // Effective image size and the position of the incoming pixel.
  always_comb begin
    w_eff = WEW'(width_q);
    if (w_eff == '0) begin
      w_eff = WEW'(1);
    end else if (w_eff > WEW'(MAX_WIDTH)) begin
      w_eff = WEW'(MAX_WIDTH);
    end
    h_eff = (height_q == '0) ? PHEIGHT_W'(1) : height_q;
    c_eff = (WEW'(col_q) >= w_eff) ? '0 : col_q;
    r_eff = (row_q >= h_eff) ? '0 : row_q;
    c_inc = WEW'(c_eff) + WEW'(1);
    r_inc = (PHEIGHT_W + 1)'(r_eff) + (PHEIGHT_W + 1)'(1);
    emit_d = (r_eff >= PHEIGHT_W'(KERNEL_SIZE - 1)) &&
             (WEW'(c_eff) >= WEW'(KERNEL_SIZE - 1));
    last_d = (r_eff == h_eff - PHEIGHT_W'(1)) && (WEW'(c_eff) == w_eff - WEW'(1));
    col_d = c_inc[CW-1:0];
    row_d = r_eff;
    if (c_inc >= w_eff) begin
      col_d = '0;
      row_d = (r_inc >= (PHEIGHT_W + 1)'(h_eff)) ? '0 : r_inc[PHEIGHT_W-1:0];
    end
  end

  // Handshake: the input register empties unless its pixel waits on the sum pipeline.
  assign s1_is_pix  = (s1_data_q.command == CMD_PIXEL);
  assign s1_go      = s1_v_q && (!(s1_is_pix && s1_emit_q) || sum_ready);
  assign in_stall_o = s1_v_q && !s1_go;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Configuration registers and raster counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= PWIDTH_RST;
      height_q <= PHEIGHT_RST;
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PADDED_WIDTH: begin
          width_q <= cfg_data_i[PWIDTH_W-1:0];
        end
        CFG_PADDED_HEIGHT: begin
          height_q <= cfg_data_i[PHEIGHT_W-1:0];
        end
        default: begin
        end
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (in_xfer && in_data_i.command == CMD_PIXEL) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Input register stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      lb_fwd_q <= 1'b0;
    end else begin
      if (in_xfer || s1_go) begin
        s1_v_q <= in_xfer;
      end
      if (in_xfer) begin
        lb_fwd_q <= s1_go && s1_is_pix && (s1_col_q == c_eff);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_data_q     <= in_data_i;
      s1_col_q      <= c_eff;
      s1_emit_q     <= emit_d && (in_data_i.command == CMD_PIXEL);
      s1_last_q     <= last_d;
      lb_fwd_data_q <= lb_wdata;
    end
  end

  // Line buffer: read at acceptance, written back when the item leaves.
  wconv_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (LB_W),
    .ADDR_W (CW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (in_xfer),
    .rd_addr_i (c_eff),
    .rd_data_o (lb_rd),
    .wr_en_i   (s1_go && s1_is_pix),
    .wr_addr_i (s1_col_q),
    .wr_data_i (lb_wdata)
  );

  // A write to the same column in the read cycle is forwarded around the memory.
  assign lb_col = lb_fwd_q ? lb_fwd_data_q : lb_rd;

  // Column of pixels, oldest row on top, and the shifted line buffer word.
  always_comb begin
    col_pix = '0;
    for (int y = 0; y + 1 < KERNEL_SIZE; y++) begin
      col_pix[y] = lb_col[KERNEL_SIZE-2-y];
    end
    col_pix[KERNEL_SIZE-1] = s1_data_q.pixel;
    lb_wdata    = '0;
    lb_wdata[0] = s1_data_q.pixel;
    for (int j = 1; j + 1 < KERNEL_SIZE; j++) begin
      lb_wdata[j] = lb_col[j-1];
    end
  end

  // Window shifts left and takes the new column on the right.
  always_comb begin
    window_d = window_q;
    for (int y = 0; y < KERNEL_SIZE; y++) begin
      for (int x = 0; x + 1 < KERNEL_SIZE; x++) begin
        window_d[y*KERNEL_SIZE+x] = window_q[y*KERNEL_SIZE+x+1];
      end
      window_d[y*KERNEL_SIZE+KERNEL_SIZE-1] = col_pix[y];
    end
  end

  // Coefficient writes; indexes past the kernel match no tap.
  always_comb begin
    kernel_d = kernel_q;
    for (int i = 0; i < TAPS; i++) begin
      if (32'(s1_data_q.coef_index) == i) begin
        kernel_d[i] = s1_data_q.coef_value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      kernel_q <= '0;
    end else if (s1_go) begin
      if (s1_is_pix) begin
        window_q <= window_d;
      end else begin
        kernel_q <= kernel_d;
      end
    end
  end

  // Sum pipeline and output register.
  assign sum_tag.valid = s1_v_q && s1_is_pix && s1_emit_q;
  assign sum_tag.last  = s1_last_q;

  wconv_sum #(
    .KERNEL_SIZE (KERNEL_SIZE)
  ) u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (sum_tag),
    .ready_o     (sum_ready),
    .window_i    (window_d),
    .kernel_i    (kernel_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // Input stalls only for an emitting pixel held by a full sum pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_v_q && s1_emit_q && s1_is_pix && !sum_ready))
    else $error("input stalled without a blocked result");

  // Raster counters stay inside the effective image.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (WEW'(col_q) < w_eff) && (row_q < h_eff))
    else $error("raster counter outside the image");

  // Forwarding is armed only when the pixel ahead left in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !(s1_go && s1_is_pix)) |=> !lb_fwd_q)
    else $error("line buffer forward without a pending write");
`endif

endmodule

`default_nettype wire

@@ test/window_convolution_2d_core_tb.sv @@
// Self-checking testbench for the 2-D sliding-window convolution core.
`timescale 1ns / 1ps

module window_convolution_2d_core_tb;
  import wconv_pkg::*;

  localparam int unsigned K         = KERNEL_SIZE_DEF;
  localparam int unsigned TAPS      = K * K;
  localparam int unsigned MAXW      = MAX_WIDTH_DEF;
  localparam int unsigned RAND_GOAL = 400;
  localparam int unsigned LIMIT     = 400000;
  localparam int unsigned MAX_PRINT = 100;

  // Sizes with the width or the height below the kernel size, zero among them.
  localparam int unsigned THIN_W [6] = '{0, 1, 2, 5, 6, 4};
  localparam int unsigned THIN_H [6] = '{5, 4, 6, 0, 1, 2};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  wconv_in_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  wconv_out_t out_data;

  // Items waiting to be driven and filtered values still due.
  wconv_in_t  pending_q[$];
  wconv_out_t filtered_q[$];

  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned random_items = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        in_taken = 1'b0;

  // Shadow copy of the core: kernel, line memories, window, raster position, image size.
  logic signed [COEF_W-1:0] kernel_coef [TAPS];
  logic [PIXEL_W-1:0]       line_mem [K-1][MAXW];
  logic [PIXEL_W-1:0]       window_px [TAPS];
  int unsigned              col_pos;
  int unsigned              row_pos;
  logic [PWIDTH_W-1:0]      img_width;
  logic [PHEIGHT_W-1:0]     img_height;

  window_convolution_2d_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINT) begin
      $display("ERROR cycle %0d: %s", cycle_count, what);
    end
    mismatch_count++;
  endtask

  // Advance the shadow core by one accepted item and queue the filtered value it yields, if any.
  task automatic convolve_item(input wconv_in_t item);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    logic [PIXEL_W-1:0] column [K];
    longint acc;
    wconv_out_t res;
    if (item.command == CMD_COEF) begin
      // Writes past the last tap are dropped.
      if (item.coef_index < TAPS) begin
        kernel_coef[item.coef_index] = item.coef_value;
      end
      return;
    end
    w = img_width;
    if (w == 0) w = 1;
    if (w > MAXW) w = MAXW;
    h = img_height;
    if (h == 0) h = 1;
    c = col_pos;
    r = row_pos;
    if (c >= w) c = 0;
    if (r >= h) r = 0;

    // Column of K pixels, oldest row first, then push the new pixel into the line memories.
    for (int unsigned y = 0; y < K - 1; y++) begin
      column[y] = line_mem[K-2-y][c];
    end
    column[K-1] = item.pixel;
    for (int unsigned y = K - 2; y > 0; y--) begin
      line_mem[y][c] = line_mem[y-1][c];
    end
    line_mem[0][c] = item.pixel;

    // Slide the window left and insert the new column on the right.
    for (int unsigned y = 0; y < K; y++) begin
      for (int unsigned x = 0; x < K - 1; x++) begin
        window_px[y*K+x] = window_px[y*K+x+1];
      end
      window_px[y*K+K-1] = column[y];
    end

    if (r >= K - 1 && c >= K - 1) begin
      acc = 0;
      for (int unsigned t = 0; t < TAPS; t++) begin
        acc += longint'(window_px[t]) * longint'(kernel_coef[t]);
      end
      res.filtered_value = acc[RESULT_W-1:0];
      res.last_of_image  = (r == h - 1) && (c == w - 1);
      filtered_q.push_back(res);
    end

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  // Check each output transfer against the oldest filtered value, then model each input transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d last %0b",
                                    out_data.filtered_value, out_data.last_of_image));
        end else begin
          if (out_data.filtered_value !== filtered_q[0].filtered_value) begin
            report_mismatch($sformatf("filtered_value got %0d want %0d",
                                      out_data.filtered_value, filtered_q[0].filtered_value));
          end
          if (out_data.last_of_image !== filtered_q[0].last_of_image) begin
            report_mismatch($sformatf("last_of_image got %0b want %0b",
                                      out_data.last_of_image, filtered_q[0].last_of_image));
          end
          void'(filtered_q.pop_front());
        end
      end
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        convolve_item(in_data);
        accepted_total++;
      end
    end
  end

  // Input driver: hold a stalled item, otherwise present the next one or idle.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side stalls at random.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_item(input wconv_in_t item, input logic counts);
    pending_q.push_back(item);
    queued_total++;
    if (counts) random_items++;
  endtask

  task automatic push_coef(input int unsigned idx, input logic [COEF_W-1:0] value);
    wconv_in_t item;
    item.command    = CMD_COEF;
    item.coef_index = idx[COEF_IDX_W-1:0];
    item.coef_value = value;
    item.pixel      = PIXEL_W'($urandom_range(255));
    push_item(item, idx < TAPS);
  endtask

  task automatic push_pixel(input logic [PIXEL_W-1:0] value);
    wconv_in_t item;
    item.command    = CMD_PIXEL;
    item.coef_index = COEF_IDX_W'($urandom_range(15));
    item.coef_value = COEF_W'($urandom_range(16'hFFFF));
    item.pixel      = value;
    push_item(item, 1'b1);
  endtask

  // Random pixels, extremes now and then, with a few stray coefficient writes mixed in.
  task automatic push_stream(input int unsigned count);
    int unsigned sel;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(24) == 0) begin
        push_coef($urandom_range(15), COEF_W'($urandom_range(16'hFFFF)));
      end
      sel = $urandom_range(15);
      if (sel == 0) push_pixel(8'h00);
      else if (sel == 1) push_pixel(8'hFF);
      else push_pixel(PIXEL_W'($urandom_range(255)));
    end
  endtask

  task automatic load_kernel();
    for (int unsigned t = 0; t < TAPS; t++) begin
      push_coef(t, COEF_W'($urandom_range(16'hFFFF)));
    end
  endtask

  // Wait until every item is in and every result out, then let the pipeline empty.
  task automatic drain();
    while (accepted_total != queued_total || filtered_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  // Registers are only written while the core is idle; each write restarts the raster.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_PADDED_WIDTH) img_width = value[PWIDTH_W-1:0];
    else img_height = value[PHEIGHT_W-1:0];
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic set_pace(input int unsigned phase);
    case (phase % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 67;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 67;
      end
      default: begin
        send_idle_pct  = 35;
        recv_stall_pct = 35;
      end
    endcase
  endtask

  task automatic set_size(input int unsigned w, input int unsigned h);
    logic [4:0] junk;
    junk = 5'($urandom_range(31));
    write_reg(CFG_PADDED_WIDTH, {junk, w[PWIDTH_W-1:0]});
    write_reg(CFG_PADDED_HEIGHT, h[PHEIGHT_W-1:0]);
  endtask

  initial begin
    int unsigned phase;
    int unsigned w;
    int unsigned h;
    int unsigned area;

    // Shadow state after reset.
    img_width  = PWIDTH_RST;
    img_height = PHEIGHT_RST;
    col_pos    = 0;
    row_pos    = 0;
    for (int unsigned t = 0; t < TAPS; t++) begin
      kernel_coef[t] = '0;
      window_px[t]   = '0;
    end
    for (int unsigned y = 0; y < K - 1; y++) begin
      for (int unsigned x = 0; x < MAXW; x++) begin
        line_mem[y][x] = '0;
      end
    end

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed: extreme and ignored coefficients, pixels at the reset size.
    set_pace(0);
    push_coef(0, 16'h7FFF);
    push_coef(1, 16'h8000);
    push_coef(2, 16'h1000);
    push_coef(3, 16'hF000);
    push_coef(4, 16'h0001);
    push_coef(5, 16'hFFFF);
    push_coef(6, 16'h5555);
    push_coef(7, 16'hAAAA);
    push_coef(8, 16'h0800);
    push_coef(9, 16'h1234);
    push_coef(15, 16'hFFFF);
    push_pixel(8'hFF);
    push_pixel(8'h00);
    push_pixel(8'hA5);
    drain();

    // Smallest image: one result, flagged as last; width written with stray upper bits.
    write_reg(CFG_PADDED_WIDTH, 16'hF803);
    write_reg(CFG_PADDED_HEIGHT, 16'd3);
    for (int unsigned i = 0; i < 9; i++) begin
      push_pixel((i == 1 || i == 6) ? 8'h00 : 8'hFF);
    end
    drain();

    // Width above the maximum falls back to the maximum.
    set_pace(1);
    write_reg(CFG_PADDED_WIDTH, 16'h07FF);
    write_reg(CFG_PADDED_HEIGHT, 16'd3);
    load_kernel();
    push_stream(2 * MAXW + 8);
    drain();

    // Sizes too small for a full window never produce a result.
    for (int unsigned i = 0; i < 6; i++) begin
      set_pace(i);
      set_size(THIN_W[i], THIN_H[i]);
      push_stream(24);
      drain();
    end

    // Tallest image on the narrowest width that holds a full window.
    set_pace(3);
    set_size(3, 65535);
    load_kernel();
    push_stream(90);
    drain();

    // Random images: mostly small, now and then wider, whole frames plus a partial one.
    random_items = 0;
    phase = 0;
    while (random_items < RAND_GOAL) begin
      set_pace(phase);
      w = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 10);
      h = $urandom_range(3, 7);
      area = w * h;
      set_size(w, h);
      if ($urandom_range(2) != 0) load_kernel();
      push_stream(area * $urandom_range(1, 2) + $urandom_range(0, area - 1));
      drain();
      phase++;
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/wconv_pkg.sv
rtl/wconv_line_buf.sv
rtl/wconv_sum.sv
rtl/window_convolution_2d_core.sv
test/window_convolution_2d_core_tb.sv
